// ===== rtl/dqs_pkg.sv =====
package dqs_pkg;

    localparam int OP_W    = 3;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [VALUE_W-1:0] item_value;
    } req_item_t;

    typedef struct packed {
        logic              found;
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  entry_count;
    } rsp_item_t;

    // Command broadcast to every cell of the chain
    typedef struct packed {
        logic                      shift_r;
        logic                      shift_l;
        logic                      capture;
        logic signed [VALUE_W-1:0] value;
    } cell_ctrl_t;

endpackage

// ===== rtl/dqs_cell.sv =====
module dqs_cell (
    input  logic                               clk,
    input  dqs_pkg::cell_ctrl_t                ctrl,
    input  logic                               load,
    input  logic signed [dqs_pkg::VALUE_W-1:0] left_data,
    input  logic signed [dqs_pkg::VALUE_W-1:0] right_data,
    output logic signed [dqs_pkg::VALUE_W-1:0] data,
    output logic                               match
);
    import dqs_pkg::*;

    logic signed [VALUE_W-1:0] data_reg;
    logic signed [VALUE_W-1:0] data_next;
    logic                      match_reg;
    logic                      match_next;

    // Take the neighbor's entry on a shift, the new value on a load
    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift_r)
        begin
            data_next = left_data;
        end
        else if (ctrl.shift_l)
        begin
            data_next = right_data;
        end
        else if (load)
        begin
            data_next = ctrl.value;
        end
    end

    // Compare the held entry against the search key
    always_comb
    begin
        match_next = match_reg;
        if (ctrl.capture)
        begin
            match_next = (data_reg == ctrl.value);
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg  <= data_next;
        match_reg <= match_next;
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// ===== rtl/double_ended_queue_with_search_top.sv =====
// Bounded double-ended queue of signed 32-bit values with membership search.
// Request channel (req_valid, req_stall, req) carries one operation per item:
// push front, push back, pop front, pop back or search. Response channel
// (rsp_valid, rsp_stall, rsp) returns one item per request with a found flag,
// a status (done, pop on empty, push on full) and the count after the operation.
// Entries live in a chain of DEPTH cells kept in order, front at cell 0: a push
// at the front shifts the chain one cell back, a pop at the front shifts it one
// cell forward, a push at the back writes the cell at the current count.
// Every cell compares its entry to the key in the same cycle for a search.
// A taken request updates the cells and moves to the EVAL state; from EVAL the
// response register is loaded once it is free, so the response is registered.
// No new request is taken while an item is in EVAL; the cell update and compare
// are registered, then the match bits are reduced into the response register.
// Reset empties the queue and clears the response valid; cell contents are
// not reset. While rsp_stall is high the finished response holds and the next
// item waits in the chain until the response register frees.
module double_ended_queue_with_search_top #(
    parameter int DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  dqs_pkg::req_item_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output dqs_pkg::rsp_item_t rsp
);
    import dqs_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EVAL = 1'b1;

    logic                      state_reg;
    logic                      state_next;
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      srch_reg;
    logic                      srch_next;
    logic [STAT_W-1:0]         stat_reg;
    logic [STAT_W-1:0]         stat_next;
    logic                      rsp_valid_reg;
    logic                      rsp_valid_next;
    rsp_item_t                 rsp_reg;
    rsp_item_t                 rsp_next;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic                      do_push_b;
    logic                      out_free;
    logic                      any_hit;
    logic [CW+CNT_W-1:0]       count_ext;
    cell_ctrl_t                ctrl;
    logic [DEPTH-1:0]          load;
    logic [DEPTH-1:0]          match;
    logic [DEPTH-1:0]          valid_mask;
    logic signed [VALUE_W-1:0] cell_data [DEPTH];

    assign accept    = req_valid && !req_stall;
    assign req_stall = (state_reg == ST_EVAL);
    assign full      = (count_reg == CW'(DEPTH));
    assign empty     = (count_reg == '0);
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // Decode the operation into cell commands, count and status
    always_comb
    begin
        ctrl.shift_r = 1'b0;
        ctrl.shift_l = 1'b0;
        ctrl.capture = 1'b0;
        ctrl.value   = req.item_value;
        do_push_b    = 1'b0;
        count_next   = count_reg;
        srch_next    = srch_reg;
        stat_next    = stat_reg;
        if (accept)
        begin
            srch_next = 1'b0;
            stat_next = ST_DONE;
            unique case (req.operation)
                OP_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        stat_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.shift_r = 1'b1;
                        count_next   = count_reg + 1'b1;
                    end
                end
                OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        stat_next = ST_FULL;
                    end
                    else
                    begin
                        do_push_b  = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        stat_next = ST_EMPTY;
                    end
                    else
                    begin
                        ctrl.shift_l = 1'b1;
                        count_next   = count_reg - 1'b1;
                    end
                end
                OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        stat_next = ST_EMPTY;
                    end
                    else
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                OP_SEARCH:
                begin
                    ctrl.capture = 1'b1;
                    srch_next    = 1'b1;
                end
                default:
                begin
                    stat_next = ST_DONE;
                end
            endcase
        end
    end

    // Build the chain of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_w;
        logic signed [VALUE_W-1:0] right_w;

        if (i == 0)
        begin : g_head
            assign left_w = req.item_value;
        end
        else
        begin : g_body
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_w = cell_data[i];
        end
        else
        begin : g_inner
            assign right_w = cell_data[i+1];
        end

        assign load[i]       = do_push_b && (count_reg == CW'(i));
        assign valid_mask[i] = (CW'(i) < count_reg);

        dqs_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .load       (load[i]),
            .left_data  (left_w),
            .right_data (right_w),
            .data       (cell_data[i]),
            .match      (match[i])
        );
    end

    // Reduce the match bits of valid cells into the response
    assign any_hit   = |(match & valid_mask);
    assign count_ext = {{CNT_W{1'b0}}, count_reg};

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (out_free)
                begin
                    rsp_next.found       = srch_reg && any_hit;
                    rsp_next.status      = stat_reg;
                    rsp_next.entry_count = count_ext[CNT_W-1:0];
                    rsp_valid_next       = 1'b1;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        srch_reg <= srch_next;
        stat_reg <= stat_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_rsp_from_eval: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg) == ST_EVAL)
        else $error("response without a pending item");

    a_full_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        accept && full && (req.operation == OP_PUSH_FRONT || req.operation == OP_PUSH_BACK)
        |=> $stable(count_reg))
        else $error("push on full changed the count");

    a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(load) && !(ctrl.shift_r && ctrl.shift_l))
        else $error("conflicting cell commands");
`endif

endmodule

// ===== verif/tb_double_ended_queue_with_search_top.sv =====
module tb_double_ended_queue_with_search_top;
    import dqs_pkg::*;

    localparam int QDEPTH       = 16;
    localparam int RAND_ITEMS   = 1650;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;

    // Codes the block must treat as no-ops
    localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN, MIX_SEEK} op_mix_e;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [VALUE_W-1:0] val;
        bit                 typed;
        logic               want_found;
        logic [STAT_W-1:0]  want_status;
        logic [CNT_W-1:0]   want_count;
    } script_row_t;

    logic      clk;
    logic      rst_n;
    logic      req_valid;
    logic      req_stall;
    req_item_t req;
    logic      rsp_valid;
    logic      rsp_stall;
    rsp_item_t rsp;

    // Shadow copy of the queue
    logic signed [VALUE_W-1:0] shadow_cells [QDEPTH];
    int                        shadow_head;
    int                        shadow_count;
    rsp_item_t                 pending_rsp [$];

    int errors;
    int n_checked;
    int n_push;
    int n_push_full;
    int n_pop;
    int n_pop_empty;
    int n_search;
    int n_hit;
    int n_noop;
    bit calm;
    int hold_asks;

    // Directed sequence: empty-queue cases, no-op codes, value extremes
    script_row_t script [25] = '{
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1, 1'b0, ST_EMPTY, 5'd0},
        '{OP_POP_BACK,   32'hFFFF_FFFF, 1'b1, 1'b0, ST_EMPTY, 5'd0},
        '{OP_SEARCH,     32'h0000_0000, 1'b1, 1'b0, ST_DONE,  5'd0},
        '{OP_RSVD_5,     32'h8000_0000, 1'b1, 1'b0, ST_DONE,  5'd0},
        '{OP_RSVD_6,     32'h7FFF_FFFF, 1'b1, 1'b0, ST_DONE,  5'd0},
        '{OP_RSVD_7,     32'h0000_0000, 1'b1, 1'b0, ST_DONE,  5'd0},
        '{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, 1'b0, ST_DONE,  5'd1},
        '{OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, 1'b0, ST_DONE,  5'd2},
        '{OP_SEARCH,     32'h8000_0000, 1'b1, 1'b1, ST_DONE,  5'd2},
        '{OP_SEARCH,     32'h7FFF_FFFF, 1'b1, 1'b1, ST_DONE,  5'd2},
        '{OP_SEARCH,     32'h0000_0000, 1'b1, 1'b0, ST_DONE,  5'd2},
        '{OP_SEARCH,     32'hFFFF_FFFF, 1'b1, 1'b0, ST_DONE,  5'd2},
        '{OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b1, 1'b0, ST_DONE,  5'd3},
        '{OP_PUSH_BACK,  32'h0000_0000, 1'b1, 1'b0, ST_DONE,  5'd4},
        '{OP_RSVD_5,     32'hFFFF_FFFF, 1'b1, 1'b0, ST_DONE,  5'd4},
        '{OP_SEARCH,     32'hFFFF_FFFF, 1'b1, 1'b1, ST_DONE,  5'd4},
        '{OP_POP_FRONT,  32'h1234_5678, 1'b1, 1'b0, ST_DONE,  5'd3},
        '{OP_SEARCH,     32'hFFFF_FFFF, 1'b1, 1'b0, ST_DONE,  5'd3},
        '{OP_POP_BACK,   32'h0000_0000, 1'b1, 1'b0, ST_DONE,  5'd2},
        '{OP_SEARCH,     32'h0000_0000, 1'b1, 1'b0, ST_DONE,  5'd2},
        '{OP_SEARCH,     32'h7FFF_FFFE, 1'b0, 1'b0, ST_DONE,  5'd0},
        '{OP_SEARCH,     32'h8000_0001, 1'b0, 1'b0, ST_DONE,  5'd0},
        '{OP_POP_BACK,   32'h0000_0000, 1'b1, 1'b0, ST_DONE,  5'd1},
        '{OP_POP_FRONT,  32'h0000_0000, 1'b1, 1'b0, ST_DONE,  5'd0},
        '{OP_SEARCH,     32'h8000_0000, 1'b1, 1'b0, ST_DONE,  5'd0}
    };

    double_ended_queue_with_search_top #(
        .DEPTH(QDEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    // Apply one operation to the shadow queue and return the response it gives
    function automatic rsp_item_t deque_apply(req_item_t it);
        rsp_item_t r;
        r.found  = 1'b0;
        r.status = ST_DONE;
        case (it.operation)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                n_push++;
                if (shadow_count >= QDEPTH)
                begin
                    r.status = ST_FULL;
                    n_push_full++;
                end
                else if (it.operation == OP_PUSH_FRONT)
                begin
                    shadow_head = (shadow_head + QDEPTH - 1) % QDEPTH;
                    shadow_cells[shadow_head] = it.item_value;
                    shadow_count++;
                end
                else
                begin
                    shadow_cells[(shadow_head + shadow_count) % QDEPTH] = it.item_value;
                    shadow_count++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                n_pop++;
                if (shadow_count == 0)
                begin
                    r.status = ST_EMPTY;
                    n_pop_empty++;
                end
                else
                begin
                    if (it.operation == OP_POP_FRONT)
                        shadow_head = (shadow_head + 1) % QDEPTH;
                    shadow_count--;
                end
            end
            OP_SEARCH:
            begin
                n_search++;
                for (int i = 0; i < shadow_count; i++)
                begin
                    if (shadow_cells[(shadow_head + i) % QDEPTH] == it.item_value)
                        r.found = 1'b1;
                end
                if (r.found)
                    n_hit++;
            end
            default:
                n_noop++;
        endcase
        r.entry_count = CNT_W'(shadow_count);
        return r;
    endfunction

    // Sender idle length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 2);
        else if (r < 97)
            return $urandom_range(3, 8);
        else
            return $urandom_range(15, 50);
    endfunction

    // Value for a push or a search: stored entries, near misses, extremes, random
    function automatic logic [VALUE_W-1:0] draw_value(bit seek);
        int                 r;
        logic [VALUE_W-1:0] v;
        r = $urandom_range(0, 9);
        if (seek && shadow_count > 0 && r < 6)
        begin
            v = shadow_cells[(shadow_head + $urandom_range(0, shadow_count - 1)) % QDEPTH];
            if (r == 5)
                v[$urandom_range(0, VALUE_W - 1)] ^= 1'b1;
            return v;
        end
        case ($urandom_range(0, 7))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'h0000_0000;
            3:       v = 32'hFFFF_FFFF;
            4:       v = VALUE_W'($urandom_range(0, 7));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Pick an operation weighted by the current mix
    function automatic req_item_t draw_item(op_mix_e mix);
        req_item_t it;
        int        r;
        int        push_pct;
        int        pop_pct;
        r = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin push_pct = 70; pop_pct = 12; end
            MIX_DRAIN: begin push_pct = 12; pop_pct = 70; end
            MIX_SEEK:  begin push_pct = 25; pop_pct = 20; end
            default:   begin push_pct = 40; pop_pct = 40; end
        endcase
        if (r < 3)
        begin
            case ($urandom_range(0, 2))
                0:       it.operation = OP_RSVD_5;
                1:       it.operation = OP_RSVD_6;
                default: it.operation = OP_RSVD_7;
            endcase
        end
        else if (r < 3 + push_pct)
            it.operation = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        else if (r < 3 + push_pct + pop_pct)
            it.operation = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
        else
            it.operation = OP_SEARCH;
        it.item_value = draw_value(it.operation == OP_SEARCH);
        return it;
    endfunction

    // Offer one item after an optional gap; return once it is taken
    task automatic offer_item(req_item_t it, int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Stimulus
    initial
    begin
        req_item_t it;
        rsp_item_t want;
        op_mix_e   mix;
        int        seg_left;
        int        n_rand;

        rst_n        = 1'b0;
        req_valid    = 1'b0;
        req          = '0;
        calm         = 1'b0;
        hold_asks    = 0;
        shadow_head  = 0;
        shadow_count = 0;
        errors       = 0;
        n_checked    = 0;
        n_push       = 0;
        n_push_full  = 0;
        n_pop        = 0;
        n_pop_empty  = 0;
        n_search     = 0;
        n_hit        = 0;
        n_noop       = 0;
        mix          = MIX_EVEN;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Walk the directed table; typed rows override the shadow's answer
        foreach (script[k])
        begin
            it.operation  = script[k].op;
            it.item_value = script[k].val;
            offer_item(it, pick_gap());
            want = deque_apply(it);
            if (script[k].typed)
            begin
                want.found       = script[k].want_found;
                want.status      = script[k].want_status;
                want.entry_count = script[k].want_count;
            end
            pending_rsp.push_back(want);
        end

        // Random segments of fill, drain, even and search-heavy traffic
        hold_asks++;
        n_rand   = 0;
        seg_left = 0;
        while (n_rand < RAND_ITEMS)
        begin
            if (seg_left == 0)
            begin
                mix      = op_mix_e'($urandom_range(0, 3));
                seg_left = $urandom_range(20, 60);
                calm     = ($urandom_range(0, 5) == 0);
            end
            if (n_rand == RAND_ITEMS / 2)
                hold_asks++;
            it = draw_item(mix);
            offer_item(it, pick_gap());
            pending_rsp.push_back(deque_apply(it));
            n_rand++;
            seg_left--;
        end
        @(negedge clk);
        req_valid <= 1'b0;

        // Drain outstanding responses, then watch for strays
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d pushes (%0d on full), %0d pops (%0d on empty),",
                 n_push, n_push_full, n_pop, n_pop_empty);
        $display("%0d searches (%0d hits), %0d no-ops; checked %0d responses, %0d mismatches.",
                 n_search, n_hit, n_noop, n_checked, errors);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Response stall: random runs, plus a long hold-off on request
    initial
    begin
        int stall_left;
        int quiet_left;
        int r;
        int hold_done;

        rsp_stall  = 1'b0;
        stall_left = 0;
        quiet_left = 0;
        hold_done  = 0;
        forever
        begin
            @(negedge clk);
            if (hold_asks != hold_done)
            begin
                hold_done  = hold_asks;
                stall_left = HOLD_CYCLES;
                quiet_left = 0;
            end
            if (stall_left == 0 && quiet_left == 0)
            begin
                r = $urandom_range(0, 9);
                if (calm)
                    quiet_left = $urandom_range(10, 40);
                else if (r < 4)
                    quiet_left = $urandom_range(1, 6);
                else if (r == 4)
                    quiet_left = $urandom_range(30, 120);
                else if (r < 9)
                    stall_left = $urandom_range(1, 3);
                else
                    stall_left = $urandom_range(6, 25);
            end
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                quiet_left--;
            end
        end
    end

    // Compare each taken response with the oldest expectation
    initial
    begin
        rsp_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_valid === 1'b1 && !rsp_stall)
            begin
                if (pending_rsp.size() == 0)
                begin
                    $display("%0t: response with nothing pending: actual %p", $time, rsp);
                    errors++;
                end
                else
                begin
                    want = pending_rsp.pop_front();
                    n_checked++;
                    if (rsp.found !== want.found)
                    begin
                        $display("%0t: found mismatch: expected %0b actual %0b",
                                 $time, want.found, rsp.found);
                        errors++;
                    end
                    if (rsp.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d actual %0d",
                                 $time, want.status, rsp.status);
                        errors++;
                    end
                    if (rsp.entry_count !== want.entry_count)
                    begin
                        $display("%0t: entry_count mismatch: expected %0d actual %0d",
                                 $time, want.entry_count, rsp.entry_count);
                        errors++;
                    end
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("%0t: timeout with %0d responses outstanding", $time, pending_rsp.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== double_ended_queue_with_search_top.f =====
rtl/dqs_pkg.sv
rtl/dqs_cell.sv
rtl/double_ended_queue_with_search_top.sv
verif/tb_double_ended_queue_with_search_top.sv
